// File: hw/rtl/ssrl_pkg.sv
// Shared constants, codes and state types for the smoothed send-rate limiter.
package ssrl_pkg;

  localparam int RING_DEPTH_DEFAULT = 16;
  localparam int MS_PER_S           = 1000;
  localparam logic [15:0] WINDOW_MS_RESET = 16'd2000;

  localparam int TIME_W   = 32;
  localparam int BYTES_W  = 16;
  localparam int LIMIT_W  = 31;
  localparam int WINDOW_W = 16;
  localparam int RATE_W   = 32;
  localparam int COUNT_W  = 4;
  localparam int DIV_W    = 42;
  localparam int STEP_W   = 6;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic {
    REG_SPEED_LIMIT = 1'b0,
    REG_WINDOW_MS   = 1'b1
  } reg_index_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_DIV  = 6'b000100,
    S_PUSH = 6'b001000,
    S_AVG  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  typedef enum logic {
    DIV_RATE = 1'b0,
    DIV_AVG  = 1'b1
  } div_phase_t;

endpackage

// File: hw/rtl/smoothed_send_rate_limiter_core.sv
// Smoothed send-rate limiter: meters bytes per second over a ring of rate samples.
// Each beat carries a millisecond timestamp and the bytes completed since the
// previous beat, and returns one result beat. A beat that does not close a
// measurement interval goes through S_DONE to the output register; one that closes
// it runs S_MUL, S_DIV, S_PUSH, S_AVG, S_DIV: one shared restoring divider, one
// quotient bit per cycle, computes bytes*1000/elapsed (42 steps) and then the ring
// average (32+log2(RING_DEPTH) steps). The rate samples sit in a RAM of RING_DEPTH
// entries holding at most RING_DEPTH-1 samples; the running sum is kept
// incrementally. A new beat is taken while the previous result waits.
module smoothed_send_rate_limiter_core
  import ssrl_pkg::*;
#(
  parameter int RING_DEPTH = ssrl_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] now_ms, [47:32] sent_bytes
  input  logic [ssrl_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] send_allowed, [32:1] smoothed_speed, [36:33] window_count,
  // [37] sample_taken, [39:38] zero
  output logic [ssrl_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ssrl_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ssrl_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ssrl_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int IW   = $clog2(RING_DEPTH);
  localparam int SUMW = RATE_W + IW;

  state_t           state;
  div_phase_t       phase;

  logic [LIMIT_W-1:0]  speed_limit;
  logic [WINDOW_W-1:0] window_ms;
  logic [TIME_W-1:0]   interval_start;
  logic                interval_started;
  logic [TIME_W-1:0]   byte_accumulator;
  logic [IW-1:0]       ring_head;
  logic [IW-1:0]       ring_tail;
  logic [SUMW-1:0]     window_sum;
  logic [RATE_W-1:0]   speed;
  logic [TIME_W-1:0]   now_hold;
  logic [RATE_W-1:0]   drop_rate;

  logic [DIV_W-1:0]    dvd;
  logic [31:0]         rem;
  logic [31:0]         divisor;
  logic [STEP_W-1:0]   steps;

  logic                taken;

  logic [TIME_W-1:0]   in_now;
  logic [BYTES_W-1:0]  in_bytes;
  logic                in_beat;
  logic                cfg_write;
  reg_index_t          cfg_index;

  logic [TIME_W:0]     acc_sum;
  logic [TIME_W-1:0]   acc_next;
  logic [TIME_W-1:0]   elapsed;

  logic [32:0]         shifted;
  logic                q_bit;

  logic [RATE_W-1:0]   rate;
  logic [IW-1:0]       tail_next;
  logic                ring_full;
  logic [IW-1:0]       head_next;
  logic [SUMW-1:0]     sum_next;
  logic [IW-1:0]       count;
  logic [SUMW:0]       limit_prod;
  logic                allowed;
  logic                out_free;
  logic [RATE_W-1:0]   ram_rdata;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
    next_slot = (i == IW'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] held(input logic [IW-1:0] t, input logic [IW-1:0] h);
    logic [IW:0] wide;
    if (t >= h) begin
      wide = {1'b0, t} - {1'b0, h};
    end else begin
      wide = {1'b0, t} + (IW+1)'(RING_DEPTH) - {1'b0, h};
    end
    held = wide[IW-1:0];
  endfunction

  assign in_now    = s_tdata[TIME_W-1:0];
  assign in_bytes  = s_tdata[TIME_W+BYTES_W-1:TIME_W];
  assign s_tready  = (state == S_IDLE);
  assign in_beat   = s_tvalid && s_tready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[2]);

  always_comb begin
    case (reg_index_t'(paddr[2]))
      REG_SPEED_LIMIT: prdata = {1'b0, speed_limit};
      REG_WINDOW_MS:   prdata = {16'b0, window_ms};
      default:         prdata = '0;
    endcase
  end

  assign acc_sum  = {1'b0, byte_accumulator} + {17'b0, in_bytes};
  assign acc_next = acc_sum[TIME_W] ? '1 : acc_sum[TIME_W-1:0];
  assign elapsed  = in_now - interval_start;

  assign shifted = {rem, dvd[DIV_W-1]};
  assign q_bit   = (shifted >= {1'b0, divisor});

  assign rate      = (|dvd[DIV_W-1:RATE_W]) ? '1 : dvd[RATE_W-1:0];
  assign tail_next = next_slot(ring_tail);
  assign ring_full = (tail_next == ring_head);
  assign head_next = ring_full ? next_slot(ring_head) : ring_head;
  assign sum_next  = window_sum + SUMW'(rate) - (ring_full ? SUMW'(drop_rate) : '0);

  assign count      = held(ring_tail, ring_head);
  assign limit_prod = (SUMW+1)'(speed_limit) * (SUMW+1)'(count);
  assign allowed    = !((speed_limit != '0) && ({1'b0, window_sum} > limit_prod));
  assign out_free   = !m_tvalid || m_tready;

  ssrl_ram #(
    .WIDTH (RATE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state == S_PUSH),
    .waddr (ring_tail),
    .wdata (rate),
    .raddr (ring_head),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      phase            <= DIV_RATE;
      speed_limit      <= '0;
      window_ms        <= WINDOW_MS_RESET;
      interval_start   <= '0;
      interval_started <= 1'b0;
      byte_accumulator <= '0;
      ring_head        <= '0;
      ring_tail        <= '0;
      window_sum       <= '0;
      speed            <= '0;
      steps            <= '0;
      taken            <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_SPEED_LIMIT: begin
            speed_limit      <= pwdata[LIMIT_W-1:0];
            byte_accumulator <= '0;
            interval_started <= 1'b0;
            interval_start   <= '0;
            if (pwdata[LIMIT_W-1:0] == '0) begin
              ring_head  <= '0;
              ring_tail  <= '0;
              window_sum <= '0;
              speed      <= '0;
            end
          end
          REG_WINDOW_MS: window_ms <= pwdata[WINDOW_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            byte_accumulator <= acc_next;
            if (speed_limit != '0 && interval_started &&
                elapsed > {16'b0, window_ms}) begin
              divisor  <= elapsed;
              now_hold <= in_now;
              taken    <= 1'b1;
              state    <= S_MUL;
            end else begin
              if (speed_limit != '0 && !interval_started) begin
                interval_started <= 1'b1;
                interval_start   <= in_now;
              end
              taken <= 1'b0;
              state <= S_DONE;
            end
          end
        end
        S_MUL: begin
          dvd       <= DIV_W'(byte_accumulator) * DIV_W'(MS_PER_S);
          rem       <= '0;
          steps     <= STEP_W'(DIV_W);
          phase     <= DIV_RATE;
          drop_rate <= ram_rdata;
          state     <= S_DIV;
        end
        S_DIV: begin
          if (steps != '0) begin
            rem   <= q_bit ? 32'(shifted - {1'b0, divisor}) : shifted[31:0];
            dvd   <= {dvd[DIV_W-2:0], q_bit};
            steps <= steps - 1'b1;
          end else if (phase == DIV_RATE) begin
            state <= S_PUSH;
          end else begin
            speed <= dvd[RATE_W-1:0];
            state <= S_DONE;
          end
        end
        S_PUSH: begin
          ring_tail        <= tail_next;
          ring_head        <= head_next;
          window_sum       <= sum_next;
          interval_start   <= now_hold;
          byte_accumulator <= '0;
          state            <= S_AVG;
        end
        S_AVG: begin
          dvd     <= DIV_W'(window_sum) << (DIV_W - SUMW);
          rem     <= '0;
          divisor <= 32'(count);
          steps   <= STEP_W'(SUMW);
          phase   <= DIV_AVG;
          state   <= S_DIV;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= {2'b00, taken, COUNT_W'(count), speed, allowed};
    end
  end

endmodule

// File: hw/rtl/ssrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ssrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
